// ----- rtl/core/bmf_pkg.sv -----
// Shared types and constants for the 7x7 box mean filter.
`default_nettype none

package bmf_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 9;
  localparam int IMG_W_W    = 10;
  localparam int IMG_H_W    = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(512);
  localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // Per-request bookkeeping that travels alongside the datapath
  typedef struct packed {
    logic                 emit;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } bmf_tag_t;

  typedef struct packed {
    logic                 last;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic [PIX_W-1:0]     mean;
  } bmf_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/bmf_line_cell.sv -----
// One line store cell: a row-deep pixel memory with registered read.
`default_nettype none

module bmf_line_cell
  import bmf_pkg::*;
#(
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]         wr_data,
  output logic      [PIX_W-1:0]         rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

`default_nettype wire

// ----- rtl/core/bmf_col_window.sv -----
// Vertical column sum and the sliding chain of column sums with running total.
`default_nettype none

module bmf_col_window
  import bmf_pkg::*;
#(
  parameter int RADIUS = 3
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     step,
  input  wire logic [PIX_W-1:0]                         pix,
  input  wire logic [2*RADIUS-1:0][PIX_W-1:0]           lines,
  output logic [PIX_W+$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] total
);

  localparam int LINES = 2 * RADIUS;
  localparam int WIN   = LINES + 1;
  localparam int CSW   = PIX_W + $clog2(WIN);
  localparam int TW    = PIX_W + $clog2(WIN * WIN);

  logic [CSW-1:0] csum;
  logic [CSW-1:0] cs_r [WIN];
  logic [TW-1:0]  total_r;
  logic [TW-1:0]  total_nxt;

  always_comb begin
    csum = CSW'(pix);
    for (int k = 0; k < LINES; k++) begin
      csum = csum + CSW'(lines[k]);
    end
  end

  // oldest column leaves the window as the new one enters
  assign total_nxt = total_r - TW'(cs_r[0]) + TW'(csum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WIN; k++) begin
        cs_r[k] <= '0;
      end
      total_r <= '0;
    end else if (step) begin
      for (int k = 0; k < WIN - 1; k++) begin
        cs_r[k] <= cs_r[k+1];
      end
      cs_r[WIN-1] <= csum;
      total_r     <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

`default_nettype wire

// ----- rtl/core/bmf_mean_div.sv -----
// Window sum to mean: multiply by a rounded-up reciprocal of the window area.
`default_nettype none

module bmf_mean_div
  import bmf_pkg::*;
#(
  parameter int RADIUS = 3
) (
  input  wire logic                                          clk,
  input  wire logic                                          en,
  input  wire logic [PIX_W+$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] total,
  output logic [PIX_W-1:0]                                   mean
);

  localparam int AREA = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int TW   = PIX_W + $clog2(AREA);
  localparam int SH   = TW + $clog2(AREA);
  localparam int RECIP = ((1 << SH) + AREA - 1) / AREA;
  localparam int MW   = $clog2(RECIP + 1);
  localparam int PW   = TW + MW;

  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [PW-1:0] prod_r;

  // exact floor division for every sum below 2**TW
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= {{MW{1'b0}}, total} * {{TW{1'b0}}, RECIP_C};
    end
  end

  assign mean = prod_r[SH +: PIX_W];

endmodule

`default_nettype wire

// ----- rtl/core/box_mean_filter_7x7.sv -----
// Top level of the streaming 7x7 box mean filter.
//
//  Channel  Direction  Signals                      Contents (lowest bit up)
//  in_      slave      in_tvalid/tready/tdata/tuser tdata: pixel[7:0]; tuser: frame_start
//  out_     master     out_tvalid/tready/tdata/tlast tdata: mean, center_row, center_col
//  cfg_     write      cfg_we/addr/wdata            0: image_width, 1: image_height
//
// One pixel per clock while in_tready is high. On its way to the output register a result
// passes through the line store read, the column sum and the reciprocal multiply.
// Each line store does one read and one write per cycle.
// in_tready falls only when both the output register and the skid stage hold results.
// Reset clears counters, column sums and valids; line stores are not cleared.
`default_nettype none

module box_mean_filter_7x7
  import bmf_pkg::*;
#(
  parameter int MAX_WIDTH = 512,
  parameter int RADIUS    = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tdata: pixel[7:0]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: frame_start[0]
  input  wire logic                  in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: mean[7:0], center_row[19:8], center_col[28:20], zero[31:29]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LINES = 2 * RADIUS;
  localparam int WIN   = LINES + 1;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EW    = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int DW    = (CW > COL_OUT_W) ? CW : COL_OUT_W;
  localparam int TW    = PIX_W + $clog2(WIN * WIN);

  // ---------------- configuration
  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0]      w_x;
  logic [EW-1:0]      w_clamp;
  logic [CW:0]        w_eff;
  logic [IMG_H_W-1:0] h_eff;

  always_comb begin
    w_x = EW'(img_w_r);
    if (w_x < EW'(WIN)) begin
      w_clamp = EW'(WIN);
    end else if (w_x > EW'(MAX_WIDTH)) begin
      w_clamp = EW'(MAX_WIDTH);
    end else begin
      w_clamp = w_x;
    end
    w_eff = w_clamp[CW:0];
    h_eff = (img_h_r < IMG_H_W'(WIN)) ? IMG_H_W'(WIN) : img_h_r;
  end

  // ---------------- handshake and stage enable
  logic     en;
  logic     accept;
  logic     skid_v_r;
  logic     out_v_r;
  bmf_res_t out_res_r;
  bmf_res_t skid_res_r;

  assign en        = !skid_v_r;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;

  // ---------------- raster counters
  logic [CW-1:0]    col_r;
  logic [CW-1:0]    col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [CW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [CW:0]      col_inc;
  logic [ROW_W:0]   row_inc;
  logic [DW-1:0]    ccol_d;
  bmf_tag_t         tag_cur;

  always_comb begin
    col_cur = in_tuser ? '0 : col_r;
    row_cur = in_tuser ? '0 : row_r;
    col_inc = {1'b0, col_cur} + (CW+1)'(1);
    row_inc = {1'b0, row_cur} + (ROW_W+1)'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_cur;
    end

    ccol_d       = DW'(col_cur) - DW'(RADIUS);
    tag_cur.emit = (row_cur >= ROW_W'(LINES)) && (col_cur >= CW'(LINES));
    tag_cur.last = (row_cur == h_eff - IMG_H_W'(1)) && ({1'b0, col_cur} == w_eff - (CW+1)'(1));
    tag_cur.row  = row_cur - ROW_W'(RADIUS);
    tag_cur.col  = ccol_d[COL_OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: line store read data, write-back shift
  logic                       s1_v_r;
  logic [PIX_W-1:0]           s1_pix_r;
  logic [CW-1:0]              s1_col_r;
  bmf_tag_t                   s1_tag_r;
  logic [LINES-1:0][PIX_W-1:0] line_q;
  logic                       s1_step;

  assign s1_step = en && s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_tdata[PIX_W-1:0];
      s1_col_r <= col_cur;
      s1_tag_r <= tag_cur;
    end
  end

  // each cell takes its neighbour's old entry; the top one takes the new pixel
  for (genvar k = 0; k < LINES; k++) begin : g_cell
    logic [PIX_W-1:0] cell_wd;
    if (k == LINES - 1) begin : g_top
      assign cell_wd = s1_pix_r;
    end else begin : g_mid
      assign cell_wd = line_q[k+1];
    end

    bmf_line_cell #(
      .DEPTH(MAX_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .wr_en   (s1_step),
      .wr_addr (s1_col_r),
      .wr_data (cell_wd),
      .rd_data (line_q[k])
    );
  end

  logic [TW-1:0] total;

  bmf_col_window #(
    .RADIUS(RADIUS)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_step),
    .pix   (s1_pix_r),
    .lines (line_q),
    .total (total)
  );

  // ---------------- stage 2: running total ready, stage 3: product ready
  logic       s2_v_r;
  bmf_tag_t   s2_tag_r;
  logic       s3_v_r;
  bmf_tag_t   s3_tag_r;
  logic [PIX_W-1:0] mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  bmf_mean_div #(
    .RADIUS(RADIUS)
  ) u_div (
    .clk   (clk),
    .en    (en && s2_v_r),
    .total (total),
    .mean  (mean)
  );

  // ---------------- output register and skid stage
  logic     res_v;
  bmf_res_t res;
  logic     out_fire;

  assign res_v     = s3_v_r && s3_tag_r.emit;
  assign res.mean  = mean;
  assign res.row   = s3_tag_r.row;
  assign res.col   = s3_tag_r.col;
  assign res.last  = s3_tag_r.last;
  assign out_fire  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || out_fire) begin
      out_v_r <= res_v;
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_v_r || out_fire) begin
      out_res_r <= res;
    end else if (res_v) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {(OUT_DATA_W-PIX_W-ROW_W-COL_OUT_W)'(0),
                       out_res_r.col, out_res_r.row, out_res_r.mean};

endmodule

`default_nettype wire

// ----- rtl/core/bmf_checker.sv -----
// Port-level checks for the box mean filter, bound to the top level.
`default_nettype none

module bmf_checker
  import bmf_pkg::*;
#(
  parameter int RADIUS = 3
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // input back-pressure only once a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // the skid stage fills only after the output was refused
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // centre row never lies in the top border
  a_row_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[PIX_W +: ROW_W] >= ROW_W'(RADIUS))
    else $error("result for a border row");

endmodule

bind box_mean_filter_7x7 bmf_checker #(.RADIUS(RADIUS)) u_bmf_checker (.*);

`default_nettype wire

// ----- verif/box_mean_filter_7x7_tb.sv -----
// Self-checking stream testbench for the 7x7 box mean filter, with its own window-mean predictor.
`timescale 1ns / 100ps

module box_mean_filter_7x7_tb;
  import bmf_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAX_W       = 512;
  localparam int RADIUS      = 3;
  localparam int WIN         = 2 * RADIUS + 1;
  localparam int LINES       = 2 * RADIUS;
  localparam int AREA        = WIN * WIN;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_ITEMS  = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_req_t;

  typedef enum int {
    MIX_RANDOM,
    MIX_BRIGHT,
    MIX_DARK,
    MIX_WHITE,
    MIX_BLACK
  } tone_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  box_mean_filter_7x7 #(
    .MAX_WIDTH (MAX_W),
    .RADIUS    (RADIUS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  bit [PIX_W-1:0]   line_mem [LINES][MAX_W];
  bit [10:0]        col_sums [WIN];
  bit [ROW_W-1:0]   row_cnt;
  bit [8:0]         col_cnt;
  bit [IMG_W_W-1:0] img_w = IMG_W_RST;
  bit [IMG_H_W-1:0] img_h = IMG_H_RST;

  pix_req_t pixel_q[$];
  bmf_res_t pending_means[$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  bit  in_busy = 1'b0;
  int  in_gap = 0;
  int  in_run = 0;
  int  rdy_gap = 0;
  int  rdy_run = 0;
  int  hold_left = 0;
  bit  stall_arm = 1'b0;
  bit  stall_done = 1'b0;

  function automatic int eff_w();
    if (img_w < WIN) return WIN;
    if (img_w > MAX_W) return MAX_W;
    return int'(img_w);
  endfunction

  function automatic int eff_h();
    if (img_h < WIN) return WIN;
    return int'(img_h);
  endfunction

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Mostly back to back, some short gaps, a few long ones; now and then a gap-free run
  function automatic int idle_len(inout int run);
    int r;
    if (run > 0) begin
      run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      run = $urandom_range(30, 200);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  task automatic window_mean_step(input logic [PIX_W-1:0] pix, input logic fs);
    int       w;
    int       h;
    int       col;
    int       row;
    int       total;
    bit [10:0] csum;
    bmf_res_t res;
    w = eff_w();
    h = eff_h();
    if (fs) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    col = col_cnt;
    row = row_cnt;
    // vertical sum over the stored lines, then push the new pixel in
    csum = pix;
    for (int k = 0; k < LINES; k++) csum += line_mem[k][col];
    for (int k = 0; k + 1 < LINES; k++) line_mem[k][col] = line_mem[k + 1][col];
    line_mem[LINES - 1][col] = pix;
    for (int k = 0; k + 1 < WIN; k++) col_sums[k] = col_sums[k + 1];
    col_sums[WIN - 1] = csum;
    if (row >= LINES && col >= LINES) begin
      total = 0;
      for (int k = 0; k < WIN; k++) total += col_sums[k];
      res.mean = PIX_W'(total / AREA);
      res.row  = ROW_W'(row - RADIUS);
      res.col  = COL_OUT_W'(col - RADIUS);
      res.last = (row == h - 1) && (col == w - 1);
      pending_means.push_back(res);
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_cnt = 9'(col);
    row_cnt = ROW_W'(row);
  endtask

  function automatic int queue_frame(input int n_pix, input bit with_start,
                                     input int stray_pm, input tone_t tone);
    pix_req_t r;
    for (int n = 0; n < n_pix; n++) begin
      case (tone)
        MIX_BRIGHT: r.pixel = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom) : 8'hFF;
        MIX_DARK:   r.pixel = ($urandom_range(0, 3) == 0) ? PIX_W'($urandom) : 8'h00;
        MIX_WHITE:  r.pixel = 8'hFF;
        MIX_BLACK:  r.pixel = 8'h00;
        default:    r.pixel = PIX_W'($urandom);
      endcase
      r.frame_start = (with_start && n == 0) || ($urandom_range(0, 999) < stray_pm);
      pixel_q.push_back(r);
    end
    return n_pix;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val[IMG_W_W-1:0];
      CFG_IMAGE_HEIGHT: img_h = val[IMG_H_W-1:0];
      default: ;
    endcase
  endtask

  // Wait for every request to go in and every mean to come out, then let the pipe empty
  task automatic settle();
    while (pixel_q.size() > 0 || pending_means.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pixel_q[0].pixel;
        in_tuser  <= pixel_q[0].frame_start;
        in_busy = 1'b1;
        in_gap = idle_len(in_run);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      window_mean_step(in_tdata, in_tuser);
      void'(pixel_q.pop_front());
      in_busy = 1'b0;
    end
  end

  // Result receiver; the one long hold-off starts on the first mean seen once armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_arm && !stall_done && out_tvalid) begin
      stall_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rdy_gap = idle_len(rdy_run);
    end
  end

  // Result monitor
  always @(posedge clk) begin : mon
    bmf_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_means.size() == 0) begin
        flag_error($sformatf("unexpected mean: tdata %h tlast %b", out_tdata, out_tlast));
      end else begin
        want = pending_means.pop_front();
        if (out_tdata[7:0] !== want.mean || out_tdata[19:8] !== want.row ||
            out_tdata[28:20] !== want.col || out_tdata[31:29] !== 3'b000 ||
            out_tlast !== want.last) begin
          flag_error($sformatf(
            "mismatch: exp mean %0d row %0d col %0d last %b, got mean %0d row %0d col %0d last %b pad %b",
            want.mean, want.row, want.col, want.last, out_tdata[7:0], out_tdata[19:8],
            out_tdata[28:20], out_tlast, out_tdata[31:29]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    int rand_items;
    int wv;
    int hv;
    int we;
    int he;
    int rows;
    int kind;
    bit start;
    int stray;
    rand_items = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Reset geometry, full-width rows; also fills every line store entry
    stall_arm = 1'b1;
    void'(queue_frame(MAX_W * WIN, 1'b1, 0, MIX_RANDOM));
    settle();

    // Smallest frame: saturated, black, then one that wraps in without a frame start
    write_reg(CFG_IMAGE_WIDTH, 12'd7);
    write_reg(CFG_IMAGE_HEIGHT, 12'd7);
    void'(queue_frame(AREA, 1'b1, 0, MIX_WHITE));
    void'(queue_frame(AREA, 1'b1, 0, MIX_BLACK));
    void'(queue_frame(AREA, 1'b0, 0, MIX_RANDOM));
    settle();

    // Zero geometry is raised to the minimum window
    write_reg(CFG_IMAGE_WIDTH, 12'd0);
    write_reg(CFG_IMAGE_HEIGHT, 12'd0);
    void'(queue_frame(AREA * 2, 1'b1, 0, MIX_BRIGHT));
    settle();

    // Upper bits of the width write fall outside the register
    write_reg(CFG_IMAGE_WIDTH, 12'hC10);
    write_reg(CFG_IMAGE_HEIGHT, 12'd9);
    void'(queue_frame(16 * 9, 1'b1, 0, MIX_DARK));
    settle();

    // Width above the line store is lowered to it
    write_reg(CFG_IMAGE_WIDTH, 12'd1023);
    write_reg(CFG_IMAGE_HEIGHT, 12'd7);
    void'(queue_frame(MAX_W * WIN, 1'b1, 0, MIX_RANDOM));
    settle();

    // Tallest frame, abandoned mid-row by a new frame start
    write_reg(CFG_IMAGE_WIDTH, 12'd8);
    write_reg(CFG_IMAGE_HEIGHT, 12'd4095);
    void'(queue_frame(8 * 12 + 3, 1'b1, 0, MIX_RANDOM));
    void'(queue_frame(8 * 9, 1'b1, 0, MIX_RANDOM));
    settle();

    // Geometry shrinks under the counters mid-frame
    write_reg(CFG_IMAGE_WIDTH, 12'd20);
    write_reg(CFG_IMAGE_HEIGHT, 12'd12);
    void'(queue_frame(20 * 10 + 15, 1'b1, 0, MIX_RANDOM));
    settle();
    write_reg(CFG_IMAGE_WIDTH, 12'd10);
    write_reg(CFG_IMAGE_HEIGHT, 12'd8);
    void'(queue_frame(10 * 3, 1'b0, 0, MIX_RANDOM));
    settle();

    while (rand_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 8)       wv = $urandom_range(7, 24);
      else if (kind == 8) wv = $urandom_range(0, 6);
      else                wv = $urandom_range(25, 64);
      kind = $urandom_range(0, 9);
      if (kind < 7)       hv = $urandom_range(7, 14);
      else if (kind == 7) hv = $urandom_range(0, 6);
      else if (kind == 8) hv = $urandom_range(15, 30);
      else                hv = 4095;
      write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(wv));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hv));
      we = eff_w();
      he = eff_h();
      repeat ($urandom_range(1, 3)) begin
        kind  = $urandom_range(0, 9);
        rows  = (he > 40) ? $urandom_range(7, 12) : he;
        start = 1'b1;
        stray = 0;
        // mostly clean frames; a few cut short, unmarked, or hit by stray frame starts
        if (kind == 7) rows = $urandom_range(1, rows);
        if (kind == 8) start = 1'b0;
        if (kind == 9) stray = 20;
        rand_items += queue_frame(we * rows, start, stray,
                                  tone_t'($urandom_range(MIX_RANDOM, MIX_DARK)));
      end
      settle();
    end

    settle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
